### src/tkms_pkg.sv
// ---------------------------------------------------------------------------
// tkms_pkg
// Shared types and constants of the top-K minimum score tracker.
// ---------------------------------------------------------------------------
package tkms_pkg;

  // Retained list geometry
  localparam int ENTRIES  = 5;
  localparam int TAG_BITS = 32;

  // Fixed field widths
  localparam int SCORE_W    = 32;
  localparam int TAG_W      = 32;
  localparam int RANK_IN_W  = 3;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 72;  // score, tag, read_rank, zero fill
  localparam int OUT_DATA_W = 72;  // insert_rank, entry fields, zero fill

  // Width of an insertion place, which may equal ENTRIES
  localparam int CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_READ_DONE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // compare, update the list and load the result register
  } cmd_t;

endpackage

### src/tkms_ctrl.sv
// ---------------------------------------------------------------------------
// tkms_ctrl
// Controller: sequences capture and execution of one word at a time and
// owns the result register's valid flag.
// ---------------------------------------------------------------------------
module tkms_ctrl
  import tkms_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_ready_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result register can take a new result this cycle
  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Hold the result until taken, refill on execute
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### src/tkms_datapath.sv
// ---------------------------------------------------------------------------
// tkms_datapath
// Datapath: input capture, a row of sorted compare cells with an insertion
// shift, the rank read select and the result register.
// ---------------------------------------------------------------------------
module tkms_datapath
  import tkms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  input  op_e                   op_i,
  input  logic [SCORE_W-1:0]    score_i,
  input  logic [TAG_W-1:0]      tag_i,
  input  logic [RANK_IN_W-1:0]  read_rank_i,
  output status_e               status_o,
  output logic [RANK_IN_W-1:0]  insert_rank_o,
  output logic                  entry_valid_o,
  output logic [SCORE_W-1:0]    entry_score_o,
  output logic [TAG_W-1:0]      entry_tag_o
);

  // Captured input word
  op_e                 op_q;
  logic [SCORE_W-1:0]  score_q;
  logic [TAG_W-1:0]    tag_q;
  logic [RANK_IN_W-1:0] rank_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      score_q <= score_i;
      tag_q   <= tag_i;
      rank_q  <= read_rank_i;
    end
  end

  // Retained cells, rank 0 is the best
  logic signed [SCORE_W-1:0] kept_score_q [ENTRIES];
  logic [TAG_BITS-1:0]       kept_tag_q   [ENTRIES];
  logic [ENTRIES-1:0]        kept_valid_q;

  // Value each cell takes when the list shifts down past it
  logic signed [SCORE_W-1:0] shift_score [ENTRIES];
  logic [TAG_BITS-1:0]       shift_tag   [ENTRIES];
  logic [ENTRIES-1:0]        shift_valid;

  logic [ENTRIES-1:0] lt_vec;
  logic [ENTRIES-1:0] eq_vec;
  logic [CNT_W-1:0]   place;
  logic               dup;
  logic               reject;
  logic               do_insert;
  logic [TAG_BITS-1:0] new_tag;

  assign new_tag = TAG_BITS'(tag_q);

  // Per-cell compares against the offered score
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lt_vec[i] = kept_valid_q[i] && (kept_score_q[i] < $signed(score_q));
      eq_vec[i] = kept_valid_q[i] && (kept_score_q[i] == $signed(score_q));
    end
  end

  // Valid cells below the offer form a prefix, so its length is the place
  always_comb begin
    place = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      place = place + CNT_W'(lt_vec[i]);
    end
  end

  assign dup       = |eq_vec;
  assign reject    = (place == CNT_W'(ENTRIES));
  assign do_insert = cmd_i.exec && (op_q == OP_OFFER) && !dup && !reject;

  // Cell 0 never shifts; every other cell takes its upper neighbor
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign shift_score[g] = $signed(score_q);
      assign shift_tag[g]   = new_tag;
      assign shift_valid[g] = 1'b1;
    end else begin : g_body
      assign shift_score[g] = kept_score_q[g-1];
      assign shift_tag[g]   = kept_tag_q[g-1];
      assign shift_valid[g] = kept_valid_q[g-1];
    end

    // Write the offer at its place, shift the cells behind it
    always_ff @(posedge clk_i) begin
      if (do_insert) begin
        if (CNT_W'(g) == place) begin
          kept_score_q[g] <= $signed(score_q);
          kept_tag_q[g]   <= new_tag;
        end else if (CNT_W'(g) > place) begin
          kept_score_q[g] <= shift_score[g];
          kept_tag_q[g]   <= shift_tag[g];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        kept_valid_q[g] <= 1'b0;
      end else if (do_insert) begin
        if (CNT_W'(g) == place) begin
          kept_valid_q[g] <= 1'b1;
        end else if (CNT_W'(g) > place) begin
          kept_valid_q[g] <= shift_valid[g];
        end
      end
    end
  end

  // Select the cell at the requested rank; out-of-range ranks read empty
  logic                      rd_valid;
  logic signed [SCORE_W-1:0] rd_score;
  logic [TAG_BITS-1:0]       rd_tag;

  always_comb begin
    rd_valid = 1'b0;
    rd_score = '0;
    rd_tag   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if ((int'(rank_q) == i) && kept_valid_q[i]) begin
        rd_valid = 1'b1;
        rd_score = kept_score_q[i];
        rd_tag   = kept_tag_q[i];
      end
    end
  end

  // Result register
  status_e              status_q;
  logic [RANK_IN_W-1:0] insert_rank_q;
  logic                 entry_valid_q;
  logic [SCORE_W-1:0]   entry_score_q;
  logic [TAG_W-1:0]     entry_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      insert_rank_q <= '0;
      entry_valid_q <= 1'b0;
      entry_score_q <= '0;
      entry_tag_q   <= '0;
      if (op_q == OP_READ) begin
        status_q      <= ST_READ_DONE;
        entry_valid_q <= rd_valid;
        entry_score_q <= rd_score;
        entry_tag_q   <= TAG_W'(rd_tag);
      end else if (dup) begin
        status_q <= ST_DUPLICATE;
      end else if (reject) begin
        status_q <= ST_REJECTED;
      end else begin
        status_q      <= ST_INSERTED;
        insert_rank_q <= RANK_IN_W'(place);
      end
    end
  end

  assign status_o      = status_q;
  assign insert_rank_o = insert_rank_q;
  assign entry_valid_o = entry_valid_q;
  assign entry_score_o = entry_score_q;
  assign entry_tag_o   = entry_tag_q;

endmodule

### src/top_k_min_score_tracker.sv
// ---------------------------------------------------------------------------
// top_k_min_score_tracker
// Keeps the lowest scores offered so far, sorted best first, with their tags.
// ---------------------------------------------------------------------------
// Each word passes two steps: a capture step, then an execute step in which
// all compare cells test the offered score in parallel and the list
// shifts to insert it (or the requested rank is selected for a read). A
// new word is taken only after the single execute step over the cell row
// has finished for the previous one. A result register separates the
// sides: the next word is captured while the previous result still waits,
// and execution stalls only when that register is still full. An offer
// equal to a held score is dropped as a duplicate; one above the worst
// entry of a full list is rejected. Reads of an empty or out-of-range rank
// return zeros with entry_valid low.
// ---------------------------------------------------------------------------
module top_k_min_score_tracker
  import tkms_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Offer or read words
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // score[31:0], tag[63:32], read_rank[66:64]
  input  logic                  s_axis_tuser,   // operation[0]
  // Result words
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // insert_rank[2:0], entry_valid[3],
                                                // entry_score[35:4], entry_tag[67:36]
  output logic [STATUS_W-1:0]   m_axis_tuser    // status[1:0]
);

  cmd_t                 cmd;
  status_e              status;
  logic [RANK_IN_W-1:0] insert_rank;
  logic                 entry_valid;
  logic [SCORE_W-1:0]   entry_score;
  logic [TAG_W-1:0]     entry_tag;

  tkms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  tkms_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (op_e'(s_axis_tuser)),
    .score_i       (s_axis_tdata[SCORE_W-1:0]),
    .tag_i         (s_axis_tdata[SCORE_W+TAG_W-1:SCORE_W]),
    .read_rank_i   (s_axis_tdata[SCORE_W+TAG_W+RANK_IN_W-1:SCORE_W+TAG_W]),
    .status_o      (status),
    .insert_rank_o (insert_rank),
    .entry_valid_o (entry_valid),
    .entry_score_o (entry_score),
    .entry_tag_o   (entry_tag)
  );

  // Pack the result word, zero filled to whole bytes
  assign m_axis_tdata = OUT_DATA_W'({entry_tag, entry_score, entry_valid, insert_rank});
  assign m_axis_tuser = status;

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench of the top-K minimum score tracker. A queue of offer and read
// words feeds a stream driver. A monitor predicts each accepted word against
// its own copy of the sorted list and checks every result word in order.
// ---------------------------------------------------------------------------
module tb
  import tkms_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    op_e                       op;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
    logic [RANK_IN_W-1:0]      rank;
  } tracker_word_t;

  typedef struct {
    status_e             status;
    logic [2:0]          insert_rank;
    logic                entry_valid;
    logic [SCORE_W-1:0]  entry_score;
    logic [TAG_W-1:0]    entry_tag;
  } tracker_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // score, tag, read_rank, zero fill
  logic                  s_axis_tuser = 1'b0; // operation
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // insert_rank, entry_valid,
                                              // entry_score, entry_tag
  logic [STATUS_W-1:0]   m_axis_tuser;        // status

  // Predictor copy of the retained list, best first
  logic signed [SCORE_W-1:0] kept_score [ENTRIES];
  logic [TAG_W-1:0]          kept_tag   [ENTRIES];
  bit                        kept_valid [ENTRIES];

  tracker_word_t   word_queue [$];
  tracker_result_t expected_results [$];

  int  fail_count = 0;
  int  status_count [4];
  bit  word_taken = 1'b0;
  bit  no_idle = 1'b0;
  int  send_wait = 0;
  int  recv_wait = 0;

  top_k_min_score_tracker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock: 2 ns high, 2 ns low
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Work out the result of one word and update the retained list
  function automatic tracker_result_t predict_tracker(tracker_word_t w);
    tracker_result_t  r;
    int               place;
    bit               dup;
    logic [TAG_W-1:0] tag_kept;
    r.status      = ST_INSERTED;
    r.insert_rank = '0;
    r.entry_valid = 1'b0;
    r.entry_score = '0;
    r.entry_tag   = '0;
    if (w.op == OP_READ) begin
      r.status = ST_READ_DONE;
      if (w.rank < ENTRIES && kept_valid[w.rank]) begin
        r.entry_valid = 1'b1;
        r.entry_score = kept_score[w.rank];
        r.entry_tag   = kept_tag[w.rank];
      end
      return r;
    end
    place = 0;
    dup   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!kept_valid[i]) break;
      if (kept_score[i] == w.score) dup = 1'b1;
      if (kept_score[i] < w.score) place = i + 1;
    end
    if (dup) begin
      r.status = ST_DUPLICATE;
      return r;
    end
    if (place >= ENTRIES) begin
      r.status = ST_REJECTED;
      return r;
    end
    // Shift the worse entries one rank down and drop the last
    for (int i = ENTRIES - 1; i > place; i--) begin
      kept_score[i] = kept_score[i-1];
      kept_tag[i]   = kept_tag[i-1];
      kept_valid[i] = kept_valid[i-1];
    end
    tag_kept = w.tag;
    if (TAG_BITS < TAG_W) tag_kept = w.tag & TAG_W'((64'd1 << TAG_BITS) - 64'd1);
    kept_score[place] = w.score;
    kept_tag[place]   = tag_kept;
    kept_valid[place] = 1'b1;
    r.insert_rank     = place[2:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_word(op_e op, logic [31:0] score, logic [31:0] tag,
                           logic [2:0] rank);
    tracker_word_t w;
    w.op    = op;
    w.score = score;
    w.tag   = tag;
    w.rank  = rank;
    word_queue = {word_queue, w};
  endtask

  // Predict accepted words, then check result words
  always @(posedge clk_i) begin : watch_words
    tracker_word_t   w;
    tracker_result_t exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        w.op    = op_e'(s_axis_tuser);
        w.score = s_axis_tdata[31:0];
        w.tag   = s_axis_tdata[63:32];
        w.rank  = s_axis_tdata[66:64];
        expected_results = {expected_results, predict_tracker(w)};
        word_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no pending expectation");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          status_count[exp_r.status]++;
          check_field("status", 32'(exp_r.status), 32'(m_axis_tuser));
          check_field("insert_rank", 32'(exp_r.insert_rank), 32'(m_axis_tdata[2:0]));
          check_field("entry_valid", 32'(exp_r.entry_valid), 32'(m_axis_tdata[3]));
          check_field("entry_score", exp_r.entry_score, m_axis_tdata[35:4]);
          check_field("entry_tag", exp_r.entry_tag, m_axis_tdata[67:36]);
        end
      end
    end
  end

  // Drive input words from the queue, with random gaps
  always @(negedge clk_i) begin : drive_words
    tracker_word_t w;
    logic          next_valid;
    if (rst_ni) begin
      next_valid = s_axis_tvalid && !word_taken;
      word_taken = 1'b0;
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (word_queue.size() > 0) begin
          w = word_queue.pop_front();
          s_axis_tdata <= {5'b0, w.rank, w.tag, w.score};
          s_axis_tuser <= w.op;
          next_valid = 1'b1;
          send_wait = idle_gap();
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_wait > 0) begin
        m_axis_tready <= 1'b0;
        recv_wait--;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_wait = idle_gap();
      end
    end
  end

  // Run limit
  initial begin
    #2ms;
    $display("FAIL top_k_min_score_tracker");
    $finish;
  end

  // Stimulus and end of run
  initial begin : stimulus
    tracker_word_t w;
    int            mode;
    int            idx;
    longint        cand;
    for (int i = 0; i < ENTRIES; i++) begin
      kept_score[i] = '0;
      kept_tag[i]   = '0;
      kept_valid[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) status_count[i] = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty list, extremes, duplicates, rejects, every rank
    push_word(OP_READ,  $urandom, $urandom, 3'd0);
    push_word(OP_READ,  $urandom, $urandom, 3'd7);
    push_word(OP_OFFER, 32'h0000_0000, 32'h0000_0000, 3'd0);
    push_word(OP_OFFER, 32'h0000_0000, 32'hFFFF_FFFF, 3'd7);
    push_word(OP_OFFER, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 3'd0);
    push_word(OP_OFFER, 32'h8000_0000, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h0000_0001, $urandom, 3'd2);
    push_word(OP_OFFER, 32'hFFFF_FFFF, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h7FFF_FFFF, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h7FFF_FFFE, 32'hFFFF_FFFF, 3'd0);
    push_word(OP_OFFER, 32'h7FFF_FFFF, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h7FFF_FFFE, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h0000_0002, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h0000_0003, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h8000_0000, $urandom, 3'd0);
    push_word(OP_OFFER, 32'h8000_0001, 32'h0000_0000, 3'd0);
    for (int r = 0; r < 8; r++) push_word(OP_READ, $urandom, $urandom, 3'(r));

    // Random: mostly offers aimed at the held scores, plus reads and noise
    for (int n = 0; n < 1230; n++) begin
      while (word_queue.size() >= 3) @(posedge clk_i);
      // Hold off until the block has drained once
      if (n == 600) begin
        while (word_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
          @(posedge clk_i);
        repeat (5) @(posedge clk_i);
      end
      no_idle = (n >= 300 && n < 400);
      w.op    = OP_OFFER;
      w.score = $urandom;
      w.tag   = $urandom;
      w.rank  = 3'($urandom_range(0, 7));
      mode    = $urandom_range(0, 99);
      idx     = $urandom_range(0, ENTRIES - 1);
      if (mode < 20) begin
        w.op = OP_READ;
        if ($urandom_range(0, 3) != 0) w.rank = 3'($urandom_range(0, ENTRIES - 1));
      end else if (mode < 35) begin
        if (kept_valid[idx]) w.score = kept_score[idx];
      end else if (mode < 75) begin
        if (kept_valid[idx]) begin
          cand = longint'(kept_score[idx]) - longint'($urandom_range(1, 2000));
          if (cand >= -64'sd2147483648) w.score = cand[31:0];
        end
      end else if (mode < 88) begin
        if (kept_valid[ENTRIES-1]) begin
          cand = longint'(kept_score[ENTRIES-1]) + longint'($urandom_range(0, 50));
          if (cand <= 64'sd2147483647) w.score = cand[31:0];
        end
      end else if (mode < 92) begin
        case ($urandom_range(0, 2))
          0:       w.score = 32'h8000_0000;
          1:       w.score = 32'h7FFF_FFFF;
          default: w.score = 32'h0000_0000;
        endcase
      end
      word_queue = {word_queue, w};
    end

    // Drain and settle
    while (word_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end
    $display("Offers: %0d inserted, %0d duplicates, %0d rejected; reads: %0d",
             status_count[ST_INSERTED], status_count[ST_DUPLICATE],
             status_count[ST_REJECTED], status_count[ST_READ_DONE]);
    if (fail_count == 0) begin
      $display("PASS top_k_min_score_tracker");
    end else begin
      $display("FAIL top_k_min_score_tracker");
    end
    $finish;
  end

endmodule
